/* hw/rtl/microstep_phase_driver_assert.svh */
// ----------------------------------------------------------------------------
// microstep phase driver assertion macros
// shared property forms for the driver's concurrent checks
// ----------------------------------------------------------------------------
`ifndef MICROSTEP_PHASE_DRIVER_ASSERT_SVH
`define MICROSTEP_PHASE_DRIVER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define MPD_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mpd check failed");

// next-cycle implication, checked out of reset
`define MPD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mpd check failed");

`endif

/* hw/rtl/mpd_pkg.sv */
// ----------------------------------------------------------------------------
// mpd_pkg
// codes, widths and the coil drive decode of the microstep phase driver
// ----------------------------------------------------------------------------
package mpd_pkg;

	localparam int MULT_W  = 16;
	localparam int DIV_W   = 15;
	localparam int PHASE_W = 8;
	localparam int LEVEL_W = 8;
	localparam int DRIVE_W = 9;
	localparam int TABLE_DEPTH = 256;
	localparam int CFG_DATA_W  = 16;
	localparam int CFG_INDEX_W = 2;

	localparam logic [1:0] MODE_TICK  = 2'd0;
	localparam logic [1:0] MODE_WRITE = 2'd1;
	localparam logic [1:0] MODE_LOAD  = 2'd2;

	localparam logic [1:0] DIR_OFF     = 2'd0;
	localparam logic [1:0] DIR_FORWARD = 2'd1;
	localparam logic [1:0] DIR_REVERSE = 2'd2;

	localparam logic [CFG_INDEX_W-1:0] REG_SPEED_MULT = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SPEED_DIV  = 2'd1;

	localparam logic [PHASE_W-1:0] QUARTER_TURN = 8'd64;
	localparam logic [LEVEL_W-1:0] LEVEL_MAX    = 8'd255;

	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic [1:0]         dir;
	} coil_drive_t;

	function automatic coil_drive_t coil_decode(logic signed [DRIVE_W-1:0] v, logic off);
		coil_drive_t        d;
		logic [DRIVE_W-1:0] mag;
		mag = DRIVE_W'(-v);
		if (off || v == '0) begin
			d.level = '0;
			d.dir   = DIR_OFF;
		end else if (!v[DRIVE_W-1]) begin
			d.level = v[LEVEL_W-1:0];
			d.dir   = DIR_FORWARD;
		end else begin
			d.level = mag[DRIVE_W-1] ? LEVEL_MAX : mag[LEVEL_W-1:0];
			d.dir   = DIR_REVERSE;
		end
		return d;
	endfunction

endpackage

/* hw/rtl/mpd_in_if.sv */
// ----------------------------------------------------------------------------
// mpd_in_if
// input channel of the microstep phase driver: tick, table write, position load
// ----------------------------------------------------------------------------
interface mpd_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         mode;
	logic [7:0]         table_index;
	logic signed [8:0]  table_value;
	logic signed [31:0] new_position;

	modport source (output valid, mode, table_index, table_value, new_position, input ready);
	modport sink (input valid, mode, table_index, table_value, new_position, output ready);
endinterface

/* hw/rtl/mpd_out_if.sv */
// ----------------------------------------------------------------------------
// mpd_out_if
// result channel of the microstep phase driver: coil drive and position
// ----------------------------------------------------------------------------
interface mpd_out_if;
	logic               valid;
	logic               ready;
	logic [7:0]         coil_a_level;
	logic [1:0]         coil_a_direction;
	logic [7:0]         coil_b_level;
	logic [1:0]         coil_b_direction;
	logic signed [31:0] step_position;
	logic [7:0]         microstep_phase;

	modport source (output valid, coil_a_level, coil_a_direction, coil_b_level,
		coil_b_direction, step_position, microstep_phase, input ready);
	modport sink (input valid, coil_a_level, coil_a_direction, coil_b_level,
		coil_b_direction, step_position, microstep_phase, output ready);
endinterface

/* hw/rtl/microstep_phase_driver.sv */
// ----------------------------------------------------------------------------
// microstep_phase_driver
// two-coil stepper microstep driver with prescaled phase accumulator
// ----------------------------------------------------------------------------
// Takes one beat per clock unless the result side stalls, and returns one
// result beat per input beat through the registered drive table read, then
// the output register, which holds it until taken. The phase, position and
// prescale counter update in the cycle a beat is accepted, so ticks may arrive
// back to back. The drive table is kept as two identical 256 x 9 rams, one read
// at the phase and one at the phase plus a quarter turn; a table write in the
// same cycle as a read of that entry is forwarded. There is no clearing pass;
// table entries must be written before a tick reads them.
// ----------------------------------------------------------------------------
module microstep_phase_driver #(
	parameter int POSITION_BITS = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  wr_en,
	input  logic [mpd_pkg::CFG_INDEX_W-1:0]       wr_index,
	input  logic [mpd_pkg::CFG_DATA_W-1:0]        wr_data,
	mpd_in_if.sink                                in_ch,
	mpd_out_if.source                             out_ch
);
	import mpd_pkg::*;

	logic signed [MULT_W-1:0]  mult_q;
	logic [DIV_W-1:0]          div_q;
	logic [PHASE_W-1:0]        phase_q;
	logic [POSITION_BITS-1:0]  pos_q;
	logic [DIV_W-1:0]          cnt_q;

	logic                      accept;
	logic                      is_tick;
	logic                      div_one;
	logic [DIV_W-1:0]          cnt_inc;
	logic                      fire;
	logic signed [PHASE_W+8:0] phase_sum;
	logic signed [8:0]         carry;
	logic [PHASE_W-1:0]        phase_nx;
	logic [PHASE_W-1:0]        phase_b_nx;
	logic [POSITION_BITS-1:0]  pos_nx;
	logic [DIV_W-1:0]          cnt_nx;
	logic                      tbl_we;

	logic                      v_s1;
	logic                      adv_s1;
	logic                      hit_a_s1;
	logic                      hit_b_s1;
	logic [DRIVE_W-1:0]        fwd_s1;
	logic                      off_s1;
	logic [31:0]               pos_s1;
	logic [PHASE_W-1:0]        phase_s1;
	logic [DRIVE_W-1:0]        ram_a;
	logic [DRIVE_W-1:0]        ram_b;
	logic [DRIVE_W-1:0]        drv_a;
	logic [DRIVE_W-1:0]        drv_b;
	coil_drive_t               coil_a;
	coil_drive_t               coil_b;
	logic                      ov_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mult_q <= '0;
			div_q  <= DIV_W'(1);
		end else if (wr_en) begin
			case (wr_index)
				REG_SPEED_MULT: mult_q <= wr_data[MULT_W-1:0];
				REG_SPEED_DIV: begin
					if (wr_data[DIV_W-1:0] != '0) begin
						div_q <= wr_data[DIV_W-1:0];
					end
				end
				default: ;
			endcase
		end
	end

	// phase accumulator
	assign accept    = in_ch.valid && in_ch.ready;
	assign is_tick   = in_ch.mode == MODE_TICK;
	assign div_one   = div_q == DIV_W'(1);
	assign cnt_inc   = cnt_q + DIV_W'(1);
	assign fire      = is_tick && (div_one || cnt_inc >= div_q);
	assign phase_sum = signed'({9'd0, phase_q}) + (PHASE_W+9)'(mult_q);
	assign carry     = phase_sum[PHASE_W+8:PHASE_W];
	assign phase_nx  = fire ? phase_sum[PHASE_W-1:0] : phase_q;
	assign phase_b_nx = phase_nx + QUARTER_TURN;

	always_comb begin
		pos_nx = pos_q;
		if (in_ch.mode == MODE_LOAD) begin
			pos_nx = POSITION_BITS'(in_ch.new_position);
		end else if (fire) begin
			pos_nx = pos_q + POSITION_BITS'(carry);
		end
		cnt_nx = cnt_q;
		if (is_tick && !div_one) begin
			cnt_nx = fire ? '0 : cnt_inc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			pos_q   <= '0;
			cnt_q   <= '0;
		end else if (accept) begin
			phase_q <= phase_nx;
			pos_q   <= pos_nx;
			cnt_q   <= cnt_nx;
		end
	end

	// drive table, one copy per coil
	assign tbl_we = accept && in_ch.mode == MODE_WRITE;

	mpd_ram #(.WIDTH(DRIVE_W), .DEPTH(TABLE_DEPTH)) u_table_a (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (in_ch.table_index),
		.wdata (in_ch.table_value),
		.re    (accept),
		.raddr (phase_nx),
		.rdata (ram_a)
	);

	mpd_ram #(.WIDTH(DRIVE_W), .DEPTH(TABLE_DEPTH)) u_table_b (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (in_ch.table_index),
		.wdata (in_ch.table_value),
		.re    (accept),
		.raddr (phase_b_nx),
		.rdata (ram_b)
	);

	// read stage
	assign adv_s1      = !ov_q || out_ch.ready;
	assign in_ch.ready = !v_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			v_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hit_a_s1 <= tbl_we && in_ch.table_index == phase_nx;
			hit_b_s1 <= tbl_we && in_ch.table_index == phase_b_nx;
			fwd_s1   <= in_ch.table_value;
			off_s1   <= mult_q == '0;
			pos_s1   <= 32'(pos_nx);
			phase_s1 <= phase_nx;
		end
	end

	assign drv_a  = hit_a_s1 ? fwd_s1 : ram_a;
	assign drv_b  = hit_b_s1 ? fwd_s1 : ram_b;
	assign coil_a = coil_decode(drv_a, off_s1);
	assign coil_b = coil_decode(drv_b, off_s1);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (adv_s1) begin
			ov_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && v_s1) begin
			out_ch.coil_a_level     <= coil_a.level;
			out_ch.coil_a_direction <= coil_a.dir;
			out_ch.coil_b_level     <= coil_b.level;
			out_ch.coil_b_direction <= coil_b.dir;
			out_ch.step_position    <= pos_s1;
			out_ch.microstep_phase  <= phase_s1;
		end
	end

	assign out_ch.valid = ov_q;

	`include "microstep_phase_driver_assert.svh"

	`MPD_ASSERT_SAME(a_ready_when_out_free, !ov_q, in_ch.ready)
	`MPD_ASSERT_NEXT(a_s1_held_on_stall, v_s1 && ov_q && !out_ch.ready, v_s1)
	`MPD_ASSERT_SAME(a_off_means_zero, ov_q && out_ch.coil_a_direction == DIR_OFF,
		out_ch.coil_a_level == '0)
endmodule

/* hw/rtl/mpd_ram.sv */
// ----------------------------------------------------------------------------
// mpd_ram
// single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module mpd_ram #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
